// ===== rtl/brfo_pkg.sv =====
// Shared types and constants for the overwriting circular byte FIFO.
// Holds the request and result formats, the opcodes and the status codes.
// No dependencies.
package brfo_pkg;

  localparam int CAP_W  = 7;
  localparam int BYTE_W = 8;
  localparam int OFS_W  = 6;

  typedef enum logic [1:0] {
    OP_ENQ   = 2'd0,
    OP_DEQ   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_OVERWRITE = 2'd1;
  localparam logic [1:0] STAT_SHORT     = 2'd2;

  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    op_t               opcode;
    logic [BYTE_W-1:0] data_in;
    logic [CAP_W-1:0]  amount;
    logic [OFS_W-1:0]  offset;
    logic              discard;
  } req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_out;
    logic              data_valid;
    logic              last;
    logic [CAP_W-1:0]  occupancy;
    logic [1:0]        status;
  } res_t;

endpackage

// ===== rtl/brfo_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package needed.
module brfo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/byte_ring_fifo_overwrite.sv =====
// Top level of the overwriting circular byte FIFO.
// Depends on brfo_pkg and on brfo_ram for the byte store.
//
// Usage:
//   Requests arrive on req_valid/req_stall/req_item, results leave on
//   res_valid/res_stall/res_item. A request is taken at a clock edge where
//   req_valid is high and req_stall is low; a result likewise.
//   Enqueue, clear, a dequeue that emits no data and a peek that misses give
//   their single result in the cycle after the request is taken. A peek that
//   hits reads the byte store and gives its result through the store's read
//   register and then the result register. A dequeue that emits data gives
//   its bytes the same way, one byte per cycle while the receiver does not
//   stall, and returns to idle as the last byte enters the result register.
//   Enqueue runs at one request per cycle while the receiver does not stall.
//   When the receiver stalls, the result register holds and the block stops
//   taking requests or emitting further bytes until it is free again.
//   Reset empties the FIFO, zeroes both pointers and sets the capacity to
//   DEPTH. Writing the capacity register over the APB port empties the FIFO
//   as well; it must only be written while the block is idle.
module byte_ring_fifo_overwrite
  import brfo_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req_item,
  output logic        res_valid,
  input  logic        res_stall,
  output res_t        res_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PEEK,
    S_DEQ
  } state_t;

  state_t           state;
  logic [CAP_W-1:0] capacity;
  logic [CAP_W-1:0] count;
  logic [AW-1:0]    wp;
  logic [AW-1:0]    head;
  logic [CAP_W-1:0] rem;
  logic [1:0]       deq_status;

  logic              out_free;
  logic              req_acc;
  logic              cfg_wr;
  logic [CAP_W-1:0]  cap_wr;
  logic [CAP_W-1:0]  n_take;
  logic              short;
  logic              full;
  logic [CAP_W-1:0]  head_sum1;
  logic [CAP_W-1:0]  wp_sum1;
  logic [CAP_W-1:0]  head_sumn;
  logic [CAP_W-1:0]  peek_sum;
  logic [AW-1:0]     head_inc;
  logic [AW-1:0]     wp_inc;
  logic [AW-1:0]     head_adv;
  logic [AW-1:0]     peek_addr;
  logic              peek_hit;

  logic              ram_we;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  // The result register can take a new value when it is empty or being drained.
  assign out_free  = !res_valid || !res_stall;
  assign req_stall = !((state == S_IDLE) && out_free);
  assign req_acc   = req_valid && !req_stall;

  // Configuration port. Only the capacity register exists; the low CAP_W bits
  // of a written value are taken, zero becomes one and above DEPTH becomes DEPTH.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
  assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(capacity) : 32'd0;

  always_comb begin
    cap_wr = pwdata[CAP_W-1:0];
    if (cap_wr == '0) begin
      cap_wr = CAP_W'(1);
    end else if (cap_wr > CAP_W'(DEPTH)) begin
      cap_wr = CAP_W'(DEPTH);
    end
  end

  // Pointer arithmetic. Every index stays below the capacity, so one compare
  // and subtract is enough to wrap.
  assign n_take    = (req_item.amount < count) ? req_item.amount : count;
  assign short     = req_item.amount > count;
  assign full      = count == capacity;
  assign peek_hit  = CAP_W'(req_item.offset) < count;

  assign head_sum1 = CAP_W'(head) + CAP_W'(1);
  assign wp_sum1   = CAP_W'(wp) + CAP_W'(1);
  assign head_sumn = CAP_W'(head) + n_take;
  assign peek_sum  = CAP_W'(head) + CAP_W'(req_item.offset);

  assign head_inc  = (head_sum1 >= capacity) ? '0 : head_sum1[AW-1:0];
  assign wp_inc    = (wp_sum1 >= capacity) ? '0 : wp_sum1[AW-1:0];

  always_comb begin
    logic [CAP_W-1:0] t;
    t = (head_sumn >= capacity) ? (head_sumn - capacity) : head_sumn;
    head_adv = t[AW-1:0];
    t = (peek_sum >= capacity) ? (peek_sum - capacity) : peek_sum;
    peek_addr = t[AW-1:0];
  end

  // Store access. Enqueue writes at the write pointer in its accept cycle.
  // Reads are issued for a hitting peek, for the first byte of a dequeue,
  // and for each following byte as the previous one moves out.
  assign ram_we = req_acc && (req_item.opcode == OP_ENQ);

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = head;
    if (req_acc && (req_item.opcode == OP_PEEK) && peek_hit) begin
      ram_re    = 1'b1;
      ram_raddr = peek_addr;
    end else if (req_acc && (req_item.opcode == OP_DEQ) && !req_item.discard
                 && (n_take != '0)) begin
      ram_re    = 1'b1;
      ram_raddr = head;
    end else if ((state == S_DEQ) && out_free && (rem > CAP_W'(1))) begin
      ram_re    = 1'b1;
      ram_raddr = head_inc;
    end
  end

  brfo_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wp),
    .wdata(req_item.data_in),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_valid  <= 1'b0;
      capacity   <= CAP_W'(DEPTH);
      count      <= '0;
      wp         <= '0;
      head       <= '0;
      rem        <= '0;
      deq_status <= STAT_OK;
    end else begin
      if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      if (cfg_wr) begin
        capacity <= cap_wr;
        count    <= '0;
        wp       <= '0;
        head     <= '0;
      end
      case (state)
        S_IDLE: begin
          if (req_acc) begin
            res_valid           <= 1'b1;
            res_item.data_out   <= '0;
            res_item.data_valid <= 1'b0;
            res_item.last       <= 1'b1;
            res_item.occupancy  <= count;
            res_item.status     <= STAT_OK;
            case (req_item.opcode)
              OP_ENQ: begin
                wp <= wp_inc;
                if (full) begin
                  // The oldest byte was just overwritten, so the head moves on.
                  head            <= head_inc;
                  res_item.status <= STAT_OVERWRITE;
                end else begin
                  count              <= count + CAP_W'(1);
                  res_item.occupancy <= count + CAP_W'(1);
                end
              end
              OP_DEQ: begin
                deq_status <= short ? STAT_SHORT : STAT_OK;
                if (req_item.discard || (n_take == '0)) begin
                  count              <= count - n_take;
                  head               <= head_adv;
                  res_item.occupancy <= count - n_take;
                  res_item.status    <= short ? STAT_SHORT : STAT_OK;
                end else begin
                  res_valid <= 1'b0;
                  rem       <= n_take;
                  state     <= S_DEQ;
                end
              end
              OP_PEEK: begin
                if (peek_hit) begin
                  res_valid <= 1'b0;
                  state     <= S_PEEK;
                end else begin
                  res_item.status <= STAT_SHORT;
                end
              end
              OP_CLEAR: begin
                // Only the count is emptied; the oldest end meets the write pointer.
                count              <= '0;
                head               <= wp;
                res_item.occupancy <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_PEEK: begin
          if (out_free) begin
            res_valid           <= 1'b1;
            res_item.data_out   <= ram_rdata;
            res_item.data_valid <= 1'b1;
            res_item.last       <= 1'b1;
            res_item.occupancy  <= count;
            res_item.status     <= STAT_OK;
            state               <= S_IDLE;
          end
        end
        S_DEQ: begin
          if (out_free) begin
            res_valid           <= 1'b1;
            res_item.data_out   <= ram_rdata;
            res_item.data_valid <= 1'b1;
            res_item.last       <= rem == CAP_W'(1);
            res_item.occupancy  <= count - CAP_W'(1);
            res_item.status     <= deq_status;
            count               <= count - CAP_W'(1);
            head                <= head_inc;
            rem                 <= rem - CAP_W'(1);
            if (rem == CAP_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The FIFO never holds more than its capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= capacity)
    else $error("byte count exceeds capacity");

  // The oldest end plus the count always lands on the write pointer.
  a_ptr_consistent: assert property (@(posedge clk) disable iff (rst)
    ((CAP_W+1)'(head) + (CAP_W+1)'(count) == (CAP_W+1)'(wp)) ||
    ((CAP_W+1)'(head) + (CAP_W+1)'(count) == (CAP_W+1)'(wp) + (CAP_W+1)'(capacity)))
    else $error("head, count and write pointer disagree");

  // While emitting a dequeue there is always at least one byte left to send.
  a_deq_remaining: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEQ) |-> (rem != '0) && (rem <= count))
    else $error("dequeue sequencer ran past the held bytes");

  // A result without data carries a zero byte.
  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_item.data_valid) |-> (res_item.data_out == '0))
    else $error("result without data carries a nonzero byte");

endmodule

// ===== test/byte_ring_fifo_overwrite_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for byte_ring_fifo_overwrite: directed and random requests
// against a built-in FIFO predictor, with random gaps on both handshakes.
// Depends on brfo_pkg and the byte_ring_fifo_overwrite RTL only.
module byte_ring_fifo_overwrite_tb
  import brfo_pkg::*;
();

  localparam int FIFO_DEPTH = 64;

  // Clock and the synchronous reset, held until the main sequence releases it.
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #6 clk = ~clk;

  // Request side, result side and the APB port; the bench-driven ones are known from time zero.
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req_item  = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  res_t        res_item;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  byte_ring_fifo_overwrite u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_item  (req_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Predictor state: the byte slots, the write pointer, the number of bytes
  // held and the capacity in effect. It mirrors the block after every request
  // that the block has taken.
  logic [BYTE_W-1:0] ring_bytes [FIFO_DEPTH];
  int                wr_slot;
  int                held_bytes;
  int                ring_cap;

  // Results that the block still owes, oldest first.
  res_t expected_results [$];
  int   mismatch_count;

  // Upper bounds of the random waits on each side; a phase sets them to zero
  // to get stretches with back-to-back traffic.
  int gap_max;
  int stall_max;

  function automatic res_t make_result(logic [BYTE_W-1:0] data, logic valid, logic last_flag,
                                       int occ, logic [1:0] stat);
    res_t r;
    r.data_out   = data;
    r.data_valid = valid;
    r.last       = last_flag;
    r.occupancy  = CAP_W'(occ);
    r.status     = stat;
    return r;
  endfunction

  function automatic req_t make_request(op_t op, int data, int amount, int offset, bit discard);
    req_t r;
    r.opcode  = op;
    r.data_in = BYTE_W'(data);
    r.amount  = CAP_W'(amount);
    r.offset  = OFS_W'(offset);
    r.discard = discard;
    return r;
  endfunction

  // Slot of the oldest byte held, within the ring of ring_cap slots.
  function automatic int oldest_slot();
    int i;
    i = wr_slot + ring_cap - held_bytes;
    if (i >= ring_cap) begin
      i -= ring_cap;
    end
    return i;
  endfunction

  // Works out every result that one taken request causes, in order, and
  // advances the predictor state the same way the block must.
  task automatic predict_fifo_results(input req_t r);
    int         n;
    int         idx;
    logic [1:0] stat;
    case (r.opcode)
      OP_ENQ: begin
        stat = STAT_OK;
        if (wr_slot >= ring_cap) begin
          wr_slot = 0;
        end
        ring_bytes[wr_slot] = r.data_in;
        wr_slot++;
        if (wr_slot >= ring_cap) begin
          wr_slot = 0;
        end
        // A full ring loses its oldest byte and keeps its count.
        if (held_bytes < ring_cap) begin
          held_bytes++;
        end else begin
          stat = STAT_OVERWRITE;
        end
        expected_results.push_back(make_result('0, 1'b0, 1'b1, held_bytes, stat));
      end
      OP_DEQ: begin
        n    = (int'(r.amount) < held_bytes) ? int'(r.amount) : held_bytes;
        stat = (int'(r.amount) > held_bytes) ? STAT_SHORT : STAT_OK;
        idx  = oldest_slot();
        if (r.discard || n == 0) begin
          // Dropped bytes and empty dequeues answer with one data-less result.
          held_bytes -= n;
          expected_results.push_back(make_result('0, 1'b0, 1'b1, held_bytes, stat));
        end else begin
          for (int k = 0; k < n; k++) begin
            held_bytes--;
            expected_results.push_back(make_result(ring_bytes[idx], 1'b1, k == n - 1,
                                                   held_bytes, stat));
            idx++;
            if (idx >= ring_cap) begin
              idx = 0;
            end
          end
        end
      end
      OP_PEEK: begin
        if (int'(r.offset) >= held_bytes) begin
          expected_results.push_back(make_result('0, 1'b0, 1'b1, held_bytes, STAT_SHORT));
        end else begin
          idx = oldest_slot() + int'(r.offset);
          if (idx >= ring_cap) begin
            idx -= ring_cap;
          end
          expected_results.push_back(make_result(ring_bytes[idx], 1'b1, 1'b1, held_bytes,
                                                 STAT_OK));
        end
      end
      default: begin
        // Clear empties the count only; the write pointer stays where it is.
        held_bytes = 0;
        expected_results.push_back(make_result('0, 1'b0, 1'b1, 0, STAT_OK));
      end
    endcase
  endtask

  // Offers one request, waits for the block to take it, then leaves a random
  // gap. Called at a rising edge and returns at one. With no gap, valid simply
  // stays high for the next request.
  task automatic send_request(input req_t r);
    int gap;
    req_valid <= 1'b1;
    req_item  <= r;
    do @(posedge clk); while (req_stall);
    predict_fifo_results(r);
    gap = $urandom_range(gap_max, 0);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering requests and waits until every owed result has come out,
  // then lets the block settle.
  task automatic wait_idle();
    req_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes the capacity register through a setup and an access phase. Any
  // write empties the FIFO; the value's low seven bits are clamped to 1..DEPTH.
  task automatic write_capacity(input int value);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CAPACITY, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    ring_cap   = (value & 'h7f);
    if (ring_cap < 1) begin
      ring_cap = 1;
    end
    if (ring_cap > FIFO_DEPTH) begin
      ring_cap = FIFO_DEPTH;
    end
    wr_slot    = 0;
    held_bytes = 0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // One random request. Dequeue amounts and peek offsets mostly stay near the
  // bytes actually held so that the interesting paths are reached often.
  task automatic send_random_request(input int enq_pct);
    int pick;
    int amount;
    int offset;
    pick = $urandom_range(99, 0);
    if (pick < enq_pct) begin
      send_request(make_request(OP_ENQ, $urandom_range(255, 0), $urandom_range(64, 0),
                                $urandom_range(63, 0), 1'($urandom_range(1, 0))));
    end else if (pick < enq_pct + (100 - enq_pct) * 5 / 10) begin
      if ($urandom_range(99, 0) < 75) begin
        amount = $urandom_range((held_bytes + 2 > 64) ? 64 : held_bytes + 2, 1);
      end else begin
        amount = $urandom_range(64, 0);
      end
      send_request(make_request(OP_DEQ, $urandom_range(255, 0), amount, $urandom_range(63, 0),
                                $urandom_range(99, 0) < 20));
    end else if (pick < 95) begin
      if (held_bytes > 0 && $urandom_range(99, 0) < 80) begin
        offset = $urandom_range(held_bytes - 1, 0);
      end else begin
        offset = $urandom_range(63, 0);
      end
      send_request(make_request(OP_PEEK, $urandom_range(255, 0), $urandom_range(64, 0),
                                offset, 1'($urandom_range(1, 0))));
    end else begin
      send_request(make_request(OP_CLEAR, $urandom_range(255, 0), $urandom_range(64, 0),
                                $urandom_range(63, 0), 1'($urandom_range(1, 0))));
    end
  endtask

  // Bytes at both extremes go in, then peeks at the oldest byte, the newest
  // byte, and far beyond what is held.
  task automatic test_enqueue_peek();
    send_request(make_request(OP_ENQ, 8'h00, 0, 0, 1'b0));
    send_request(make_request(OP_ENQ, 8'hff, 0, 0, 1'b0));
    send_request(make_request(OP_PEEK, 0, 0, 0, 1'b0));
    send_request(make_request(OP_PEEK, 0, 0, 1, 1'b0));
    send_request(make_request(OP_PEEK, 0, 0, 63, 1'b1));
  endtask

  // A three-slot ring takes a fourth byte and overwrites its oldest one; then
  // a dequeue asks for far more than is held and must flag every byte short.
  task automatic test_overwrite_when_full();
    write_capacity(3);
    send_request(make_request(OP_ENQ, 8'h11, 0, 0, 1'b0));
    send_request(make_request(OP_ENQ, 8'h22, 0, 0, 1'b0));
    send_request(make_request(OP_ENQ, 8'h33, 0, 0, 1'b0));
    send_request(make_request(OP_ENQ, 8'h44, 0, 0, 1'b0));
    send_request(make_request(OP_PEEK, 0, 0, 2, 1'b0));
    send_request(make_request(OP_DEQ, 0, 64, 0, 1'b0));
    send_request(make_request(OP_DEQ, 0, 0, 0, 1'b0));
  endtask

  // Discarding dequeue, an exact dequeue, and a discarding one on an empty
  // ring that must report a short count.
  task automatic test_dequeue_modes();
    send_request(make_request(OP_ENQ, 8'haa, 0, 0, 1'b0));
    send_request(make_request(OP_ENQ, 8'h55, 0, 0, 1'b0));
    send_request(make_request(OP_DEQ, 0, 1, 0, 1'b1));
    send_request(make_request(OP_DEQ, 0, 1, 0, 1'b0));
    send_request(make_request(OP_DEQ, 0, 5, 0, 1'b1));
  endtask

  // Clear must keep the write pointer, so the next byte lands after the old ones.
  task automatic test_clear_keeps_pointer();
    send_request(make_request(OP_ENQ, 8'h5a, 0, 0, 1'b0));
    send_request(make_request(OP_CLEAR, 0, 0, 0, 1'b0));
    send_request(make_request(OP_ENQ, 8'ha5, 0, 0, 1'b0));
    send_request(make_request(OP_PEEK, 0, 0, 0, 1'b0));
  endtask

  // A capacity of zero is taken as one: every enqueue after the first overwrites.
  task automatic test_capacity_clamp();
    write_capacity(0);
    send_request(make_request(OP_ENQ, 8'h01, 0, 0, 1'b0));
    send_request(make_request(OP_ENQ, 8'h80, 0, 0, 1'b0));
    send_request(make_request(OP_PEEK, 0, 0, 0, 1'b0));
    send_request(make_request(OP_PEEK, 0, 0, 1, 1'b0));
  endtask

  // Random phases, each under a fresh capacity and its own idling bounds. The
  // first phase leans on enqueue to fill the full-size ring, and its dequeues
  // drain it in long bursts; capacities above DEPTH are clamped as well.
  task automatic test_random_traffic();
    int cap_value;
    int n_items;
    int enq_pct;
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: cap_value = 127;
        1: cap_value = 64;
        2: cap_value = 1;
        3: cap_value = 2;
        4: cap_value = 100;
        default: cap_value = $urandom_range(64, 1);
      endcase
      write_capacity(cap_value);
      gap_max   = (ph % 3 == 1) ? 0 : 19;
      stall_max = (ph % 4 == 2) ? 0 : 19;
      n_items   = (ph == 0) ? 90 : 27;
      enq_pct   = (ph == 0) ? 90 : 45;
      for (int i = 0; i < n_items; i++) begin
        send_random_request(enq_pct);
      end
    end
    gap_max   = 19;
    stall_max = 19;
  endtask

  // Result-side stall: before each result a random number of stalled cycles.
  initial begin
    int n;
    do @(posedge clk); while (rst);
    forever begin
      n = $urandom_range(stall_max, 0);
      if (n > 0) begin
        res_stall <= 1'b1;
        repeat (n) @(posedge clk);
        res_stall <= 1'b0;
      end
      do @(posedge clk); while (!(res_valid && !res_stall));
    end
  end

  // Every result taken is checked field by field against the oldest one owed.
  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result: data=%0d valid=%0d last=%0d occ=%0d status=%0d",
                   res_item.data_out, res_item.data_valid, res_item.last,
                   res_item.occupancy, res_item.status);
        end
      end else begin
        want = expected_results.pop_front();
        if (res_item.data_out !== want.data_out || res_item.data_valid !== want.data_valid ||
            res_item.last !== want.last || res_item.occupancy !== want.occupancy ||
            res_item.status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result mismatch: expected data=%0d valid=%0d last=%0d occ=%0d status=%0d",
                     want.data_out, want.data_valid, want.last, want.occupancy, want.status);
            $display("                 got      data=%0d valid=%0d last=%0d occ=%0d status=%0d",
                     res_item.data_out, res_item.data_valid, res_item.last,
                     res_item.occupancy, res_item.status);
          end
        end
      end
    end
  end

  // Main sequence: reset once, run each test in turn, drain, then judge.
  initial begin
    wr_slot        = 0;
    held_bytes     = 0;
    ring_cap       = FIFO_DEPTH;
    mismatch_count = 0;
    gap_max        = 19;
    stall_max      = 19;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_enqueue_peek();
    test_overwrite_when_full();
    test_dequeue_modes();
    test_clear_keeps_pointer();
    test_capacity_clamp();
    test_random_traffic();
    req_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("[byte_ring_fifo_overwrite] OK");
    end else begin
      $display("[byte_ring_fifo_overwrite] ERROR");
    end
    $finish;
  end

  // A hung handshake ends the run here.
  initial begin
    #20_000_000;
    $display("[byte_ring_fifo_overwrite] ERROR");
    $finish;
  end

endmodule

// ===== byte_ring_fifo_overwrite.f =====
rtl/brfo_pkg.sv
rtl/brfo_ram.sv
rtl/byte_ring_fifo_overwrite.sv
test/byte_ring_fifo_overwrite_tb.sv
